### hw/rtl/bic_pkg.sv
// ----------------------------------------------------------------------------
// bic_pkg
// Shared types and constants of the BIC congestion window core: widths,
// event codes, register indexes, arithmetic unit request and sequencer states.
// ----------------------------------------------------------------------------
package bic_pkg;

  localparam int unsigned WORD_W     = 32;  // byte and segment counts
  localparam int unsigned DIVD_W     = 40;  // dividend / quotient width
  localparam int unsigned ACC_W      = 64;  // product accumulator width
  localparam int unsigned MPL_W      = 16;  // multiplier operand width
  localparam int unsigned STEP_W     = 6;   // iteration counter width
  localparam int unsigned BETA_SHIFT = 10;  // Q0.10 scaling of beta

  localparam logic [STEP_W-1:0] MUL_STEPS = 6'd16;
  localparam logic [STEP_W-1:0] DIV_STEPS = 6'd40;

  // event codes
  localparam logic [2:0] OP_START   = 3'd0;
  localparam logic [2:0] OP_NEW_ACK = 3'd1;
  localparam logic [2:0] OP_DUP_ACK = 3'd2;
  localparam logic [2:0] OP_TIMEOUT = 3'd3;
  localparam logic [2:0] OP_SCALE   = 3'd4;

  // register indexes
  localparam logic [2:0] CFG_SEGMENT_SIZE   = 3'd0;
  localparam logic [2:0] CFG_INIT_WINDOW    = 3'd1;
  localparam logic [2:0] CFG_INIT_THRESHOLD = 3'd2;
  localparam logic [2:0] CFG_LOW_WINDOW     = 3'd3;
  localparam logic [2:0] CFG_MAX_INCREMENT  = 3'd4;
  localparam logic [2:0] CFG_SMOOTH_PART    = 3'd5;
  localparam logic [2:0] CFG_SEARCH_COEF    = 3'd6;
  localparam logic [2:0] CFG_BETA_Q10       = 3'd7;

  localparam logic [15:0]       RETX_THRESHOLD = 16'd3;
  localparam logic              FAST_CONVERGE  = 1'b1;
  localparam logic [DIVD_W-1:0] LOSS_CLAMP     = 40'd20;
  localparam logic [10:0]       BETA_ONE       = 11'd1024;

  typedef enum logic {
    ALU_MUL,
    ALU_DIV
  } alu_op_t;

  typedef struct packed {
    logic    start;
    alu_op_t op;
  } alu_req_t;

  typedef enum logic [4:0] {
    S_IDLE,
    S_DECODE,
    S_START_MUL,
    S_GROW,
    S_G_WDIV,
    S_G_DIST,
    S_G_LMUL,
    S_G_SMUL,
    S_G_SDIV,
    S_G_BMUL,
    S_G_BDIV,
    S_G_MIDIV,
    S_G_WDDIV,
    S_G_APPLY,
    S_C_WDIV,
    S_C_BMUL,
    S_C_QMUL,
    S_C_PMUL,
    S_DONE
  } ctl_state_t;

endpackage

### hw/rtl/bic_alu.sv
// ----------------------------------------------------------------------------
// bic_alu
// Shared iterative arithmetic unit: shift-add multiply, one multiplier bit
// per cycle, and restoring divide, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module bic_alu (
  input  logic                       clk,
  input  logic                       rst_n,
  input  bic_pkg::alu_req_t          req,
  input  logic [bic_pkg::ACC_W-1:0]  opa,
  input  logic [bic_pkg::WORD_W-1:0] opb,
  output logic                       done,
  output logic [bic_pkg::ACC_W-1:0]  result
);
  import bic_pkg::*;

  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;
  alu_op_t           op_r, op_nxt;
  logic [STEP_W-1:0] cnt_r, cnt_nxt;
  logic [ACC_W-1:0]  acc_r, acc_nxt;
  logic [ACC_W-1:0]  sh_r, sh_nxt;     // multiplicand, or dividend/quotient
  logic [MPL_W-1:0]  mpl_r, mpl_nxt;
  logic [WORD_W-1:0] rem_r, rem_nxt;
  logic [WORD_W-1:0] dvs_r, dvs_nxt;

  logic [WORD_W:0]   trial;
  logic [WORD_W:0]   diff;
  logic              take;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    op_r  <= op_nxt;
    acc_r <= acc_nxt;
    sh_r  <= sh_nxt;
    mpl_r <= mpl_nxt;
    rem_r <= rem_nxt;
    dvs_r <= dvs_nxt;
  end

  always_comb begin
    trial    = {rem_r, sh_r[DIVD_W-1]};
    diff     = trial - {1'b0, dvs_r};
    take     = (trial >= {1'b0, dvs_r});
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    op_nxt   = op_r;
    cnt_nxt  = cnt_r;
    acc_nxt  = acc_r;
    sh_nxt   = sh_r;
    mpl_nxt  = mpl_r;
    rem_nxt  = rem_r;
    dvs_nxt  = dvs_r;
    if (req.start) begin
      op_nxt   = req.op;
      busy_nxt = 1'b1;
      if (req.op == ALU_MUL) begin
        acc_nxt = '0;
        sh_nxt  = opa;
        mpl_nxt = opb[MPL_W-1:0];
        cnt_nxt = MUL_STEPS;
      end else begin
        sh_nxt  = {{(ACC_W-DIVD_W){1'b0}}, opa[DIVD_W-1:0]};
        rem_nxt = '0;
        dvs_nxt = opb;
        cnt_nxt = DIV_STEPS;
      end
    end else if (busy_r) begin
      if (op_r == ALU_MUL) begin
        if (mpl_r[0]) begin
          acc_nxt = acc_r + sh_r;
        end
        sh_nxt  = {sh_r[ACC_W-2:0], 1'b0};
        mpl_nxt = {1'b0, mpl_r[MPL_W-1:1]};
      end else begin
        rem_nxt = take ? diff[WORD_W-1:0] : trial[WORD_W-1:0];
        sh_nxt  = {sh_r[ACC_W-2:0], take};
      end
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == {{(STEP_W-1){1'b0}}, 1'b1}) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  assign done   = done_r;
  assign result = (op_r == ALU_MUL) ? acc_r : {{(ACC_W-DIVD_W){1'b0}}, sh_r[DIVD_W-1:0]};

endmodule

### hw/rtl/bic_congestion_window_core.sv
// ----------------------------------------------------------------------------
// bic_congestion_window_core
// TCP BIC congestion window keeper: window, slow start threshold, last
// maximum, ACK counter and loss flag, updated once per event request.
// ----------------------------------------------------------------------------
// One event request is taken at a time; in_ready is high only while the
// sequencer is idle, and a finished result sits in the output register so
// the next request can be taken while it waits. All arithmetic runs on one
// shared unit: a multiply holds the sequencer for 16 shift-add steps, a
// divide for 40 restoring steps. Work per request: start one multiply,
// threshold scale, unused codes and slow-start ACK no arithmetic,
// congestion-avoidance ACK a segment division, then depending on the BIC
// region up to three more operations (two divides and a multiply, or two
// multiplies and a divide), loss a segment division and two multiplies,
// loss while already in loss none. Configuration writes are taken every
// cycle and must only be issued while the block is idle.
// ----------------------------------------------------------------------------
module bic_congestion_window_core (
  input  logic        clk,
  input  logic        rst_n,
  // configuration write channel
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data,
  // event requests
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  in_op,
  input  logic [15:0] in_dup_count,
  input  logic [3:0]  in_scale_shift,
  input  logic [31:0] in_receiver_window,
  // results
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] out_congestion_window,
  output logic [31:0] out_slow_start_threshold,
  output logic [31:0] out_send_window,
  output logic        out_in_loss,
  output logic        out_retransmit_now,
  output logic        out_send_pending
);
  import bic_pkg::*;

  // configuration registers
  logic [15:0]       seg_r;
  logic [10:0]       init_win_r;
  logic [31:0]       init_th_r;
  logic [15:0]       low_r;
  logic [15:0]       maxinc_r;
  logic [7:0]        smooth_r;
  logic [7:0]        coef_r;
  logic [10:0]       beta_r;

  // effective values: out of range settings are pulled into range
  logic [15:0]       seg_e;
  logic [15:0]       mi_e;
  logic [7:0]        b_e;
  logic [7:0]        bm1;
  logic [10:0]       beta_e;

  // sequencer and latched request
  ctl_state_t        state_r, state_nxt;
  logic              iss_r, iss_nxt;
  logic [2:0]        op_r, op_nxt;
  logic [15:0]       dup_r, dup_nxt;
  logic [3:0]        shift_r, shift_nxt;
  logic [31:0]       rwnd_r, rwnd_nxt;

  // protocol state
  logic [WORD_W-1:0] win_r, win_nxt;
  logic [WORD_W-1:0] th_r, th_nxt;
  logic [WORD_W-1:0] lm_r, lm_nxt;
  logic [WORD_W-1:0] ack_r, ack_nxt;
  logic              loss_r, loss_nxt;
  logic              retx_r, retx_nxt;
  logic              pend_r, pend_nxt;

  // working registers
  logic [WORD_W-1:0] w_r, w_nxt;       // window in segments
  logic [WORD_W-1:0] dist_r, dist_nxt;
  logic [ACC_W-1:0]  tmp_r, tmp_nxt;
  logic [DIVD_W-1:0] cnt_r, cnt_nxt;   // ACKs needed per segment

  // output register
  logic              ov_r, ov_nxt;
  logic [31:0]       ocw_r, ocw_nxt;
  logic [31:0]       oth_r, oth_nxt;
  logic [31:0]       osw_r, osw_nxt;
  logic              oloss_r, oloss_nxt;
  logic              oretx_r, oretx_nxt;
  logic              opend_r, opend_nxt;

  // shared unit
  alu_req_t          alu_req;
  logic [ACC_W-1:0]  alu_a;
  logic [WORD_W-1:0] alu_b;
  logic              alu_done;
  logic [ACC_W-1:0]  alu_res;

  // datapath helpers
  logic [WORD_W:0]   win_add;
  logic [WORD_W-1:0] win_inc;
  logic [ACC_W-1:0]  scale_full;
  logic [WORD_W-1:0] scale_sat;
  logic [WORD_W:0]   lm_plus_b;
  logic [WORD_W:0]   lm_plus_lin;
  logic [WORD_W-1:0] qw;
  logic [16:0]       floor2;
  logic [ACC_W-1:0]  th_raw;
  logic [ACC_W-1:0]  th_fl;
  logic [WORD_W-1:0] th_sat;
  logic              alu_state;

  function automatic logic [DIVD_W-1:0] fix_count(input logic [DIVD_W-1:0] q,
                                                  input logic lm_zero);
    logic [DIVD_W-1:0] c;
    c = q;
    if (lm_zero && (c > LOSS_CLAMP)) c = LOSS_CLAMP;
    if (c == '0) c = {{(DIVD_W-1){1'b0}}, 1'b1};
    return c;
  endfunction

  function automatic logic [ACC_W-1:0] ext64(input logic [WORD_W-1:0] v);
    return {{(ACC_W-WORD_W){1'b0}}, v};
  endfunction

  // --------------------------------------------------------------------------
  // configuration
  // --------------------------------------------------------------------------
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seg_r      <= 16'd536;
      init_win_r <= 11'd1;
      init_th_r  <= 32'd65535;
      low_r      <= 16'd14;
      maxinc_r   <= 16'd16;
      smooth_r   <= 8'd5;
      coef_r     <= 8'd4;
      beta_r     <= 11'd819;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_SEGMENT_SIZE:   seg_r      <= cfg_data[15:0];
        CFG_INIT_WINDOW:    init_win_r <= cfg_data[10:0];
        CFG_INIT_THRESHOLD: init_th_r  <= cfg_data;
        CFG_LOW_WINDOW:     low_r      <= cfg_data[15:0];
        CFG_MAX_INCREMENT:  maxinc_r   <= cfg_data[15:0];
        CFG_SMOOTH_PART:    smooth_r   <= cfg_data[7:0];
        CFG_SEARCH_COEF:    coef_r     <= cfg_data[7:0];
        CFG_BETA_Q10:       beta_r     <= cfg_data[10:0];
        default: ;
      endcase
    end
  end

  assign seg_e  = (seg_r == '0) ? 16'd1 : seg_r;
  assign mi_e   = (maxinc_r == '0) ? 16'd1 : maxinc_r;
  assign b_e    = (coef_r < 8'd2) ? 8'd2 : coef_r;
  assign bm1    = b_e - 8'd1;
  assign beta_e = (beta_r > BETA_ONE) ? BETA_ONE : beta_r;

  // --------------------------------------------------------------------------
  // shared arithmetic unit
  // --------------------------------------------------------------------------
  bic_alu u_alu (
    .clk    (clk),
    .rst_n  (rst_n),
    .req    (alu_req),
    .opa    (alu_a),
    .opb    (alu_b),
    .done   (alu_done),
    .result (alu_res)
  );

  // operand select per sequencer step
  always_comb begin
    alu_a     = ext64(win_r);
    alu_b     = {16'b0, seg_e};
    alu_req.op = ALU_DIV;
    alu_state = 1'b1;
    case (state_r)
      S_START_MUL: begin
        alu_req.op = ALU_MUL;
        alu_a      = ext64({21'b0, init_win_r});
      end
      S_G_WDIV, S_C_WDIV: ;
      S_G_DIST: begin
        alu_a = ext64(lm_r - w_r);
        alu_b = {24'b0, b_e};
      end
      S_G_LMUL: begin
        alu_req.op = ALU_MUL;
        alu_a      = ext64({16'b0, mi_e});
        alu_b      = {24'b0, bm1};
      end
      S_G_SMUL: begin
        alu_req.op = ALU_MUL;
        alu_a      = ext64(w_r);
        alu_b      = {24'b0, smooth_r};
      end
      S_G_SDIV: begin
        alu_a = tmp_r;
        alu_b = {24'b0, b_e};
      end
      S_G_BMUL: begin
        alu_req.op = ALU_MUL;
        alu_a      = ext64(w_r);
        alu_b      = {24'b0, bm1};
      end
      S_G_BDIV: begin
        alu_a = tmp_r;
        alu_b = w_r - lm_r;
      end
      S_G_MIDIV: begin
        alu_a = ext64(w_r);
        alu_b = {16'b0, mi_e};
      end
      S_G_WDDIV: begin
        alu_a = ext64(w_r);
        alu_b = dist_r;
      end
      S_C_BMUL: begin
        alu_req.op = ALU_MUL;
        alu_a      = ext64(w_r);
        alu_b      = {21'b0, beta_e};
      end
      S_C_QMUL: begin
        alu_req.op = ALU_MUL;
        alu_a      = ext64({2'b0, w_r[WORD_W-1:2]});
      end
      S_C_PMUL: begin
        alu_req.op = ALU_MUL;
        alu_a      = tmp_r;
      end
      default: alu_state = 1'b0;
    endcase
    alu_req.start = alu_state && !iss_r;
  end

  // --------------------------------------------------------------------------
  // datapath helpers
  // --------------------------------------------------------------------------
  assign win_add     = {1'b0, win_r} + {17'b0, seg_e};
  assign win_inc     = win_add[WORD_W] ? '1 : win_add[WORD_W-1:0];
  assign scale_full  = ext64(th_r) << shift_r;
  assign scale_sat   = (|scale_full[ACC_W-1:WORD_W]) ? '1 : scale_full[WORD_W-1:0];
  assign lm_plus_b   = {1'b0, lm_r} + {25'b0, b_e};
  assign lm_plus_lin = {1'b0, lm_r} + alu_res[WORD_W:0];
  assign qw          = alu_res[WORD_W-1:0];
  assign floor2      = {seg_e, 1'b0};
  // loss threshold: the beta product carries the Q0.10 scale
  assign th_raw      = (state_r == S_C_PMUL) ? (alu_res >> BETA_SHIFT) : alu_res;
  assign th_fl       = (th_raw < {47'b0, floor2}) ? {47'b0, floor2} : th_raw;
  assign th_sat      = (|th_fl[ACC_W-1:WORD_W]) ? '1 : th_fl[WORD_W-1:0];

  // --------------------------------------------------------------------------
  // sequencer
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      iss_r   <= 1'b0;
      win_r   <= '0;
      th_r    <= '0;
      lm_r    <= '0;
      ack_r   <= '0;
      loss_r  <= 1'b0;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      iss_r   <= iss_nxt;
      win_r   <= win_nxt;
      th_r    <= th_nxt;
      lm_r    <= lm_nxt;
      ack_r   <= ack_nxt;
      loss_r  <= loss_nxt;
      ov_r    <= ov_nxt;
    end
    op_r    <= op_nxt;
    dup_r   <= dup_nxt;
    shift_r <= shift_nxt;
    rwnd_r  <= rwnd_nxt;
    retx_r  <= retx_nxt;
    pend_r  <= pend_nxt;
    w_r     <= w_nxt;
    dist_r  <= dist_nxt;
    tmp_r   <= tmp_nxt;
    cnt_r   <= cnt_nxt;
    ocw_r   <= ocw_nxt;
    oth_r   <= oth_nxt;
    osw_r   <= osw_nxt;
    oloss_r <= oloss_nxt;
    oretx_r <= oretx_nxt;
    opend_r <= opend_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    iss_nxt   = iss_r;
    op_nxt    = op_r;
    dup_nxt   = dup_r;
    shift_nxt = shift_r;
    rwnd_nxt  = rwnd_r;
    win_nxt   = win_r;
    th_nxt    = th_r;
    lm_nxt    = lm_r;
    ack_nxt   = ack_r;
    loss_nxt  = loss_r;
    retx_nxt  = retx_r;
    pend_nxt  = pend_r;
    w_nxt     = w_r;
    dist_nxt  = dist_r;
    tmp_nxt   = tmp_r;
    cnt_nxt   = cnt_r;
    ov_nxt    = ov_r;
    ocw_nxt   = ocw_r;
    oth_nxt   = oth_r;
    osw_nxt   = osw_r;
    oloss_nxt = oloss_r;
    oretx_nxt = oretx_r;
    opend_nxt = opend_r;
    in_ready  = 1'b0;

    if (ov_r && out_ready) ov_nxt = 1'b0;

    // compute steps: issue once, then wait for the unit
    if (alu_req.start) iss_nxt = 1'b1;
    if (iss_r && alu_done) iss_nxt = 1'b0;

    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          op_nxt    = in_op;
          dup_nxt   = in_dup_count;
          shift_nxt = in_scale_shift;
          rwnd_nxt  = in_receiver_window;
          retx_nxt  = 1'b0;
          pend_nxt  = 1'b0;
          state_nxt = S_DECODE;
        end
      end

      S_DECODE: begin
        state_nxt = S_DONE;
        case (op_r)
          OP_START: state_nxt = S_START_MUL;
          OP_NEW_ACK: begin
            loss_nxt  = 1'b0;
            state_nxt = S_GROW;
          end
          OP_DUP_ACK: begin
            if (dup_r == RETX_THRESHOLD) begin
              retx_nxt = 1'b1;
              loss_nxt = 1'b1;
              // already in loss: no second cut
              if (!loss_r) state_nxt = S_C_WDIV;
            end else if (dup_r > RETX_THRESHOLD) begin
              pend_nxt  = 1'b1;
              state_nxt = S_GROW;
            end
          end
          OP_TIMEOUT: begin
            retx_nxt = 1'b1;
            loss_nxt = 1'b1;
            if (!loss_r) state_nxt = S_C_WDIV;
          end
          OP_SCALE: th_nxt = scale_sat;
          default: ;
        endcase
      end

      S_START_MUL: begin
        if (iss_r && alu_done) begin
          win_nxt   = alu_res[WORD_W-1:0];
          th_nxt    = init_th_r;
          lm_nxt    = '0;
          loss_nxt  = 1'b0;
          state_nxt = S_DONE;
        end
      end

      // ---- growth ----
      S_GROW: begin
        if (win_r < th_r) begin
          win_nxt   = win_inc;   // slow start
          state_nxt = S_DONE;
        end else begin
          if (ack_r != '1) ack_nxt = ack_r + 1'b1;
          state_nxt = S_G_WDIV;
        end
      end

      S_G_WDIV: begin
        if (iss_r && alu_done) begin
          w_nxt = qw;
          if (qw < {16'b0, low_r}) begin
            // small window: count is the window itself, no clamp
            cnt_nxt   = {{(DIVD_W-WORD_W){1'b0}}, qw};
            state_nxt = S_G_APPLY;
          end else if (qw < lm_r) begin
            state_nxt = S_G_DIST;
          end else if ({1'b0, qw} < lm_plus_b) begin
            state_nxt = S_G_SMUL;
          end else begin
            state_nxt = S_G_LMUL;
          end
        end
      end

      S_G_DIST: begin
        if (iss_r && alu_done) begin
          dist_nxt = alu_res[WORD_W-1:0];
          if (alu_res[DIVD_W-1:0] > {24'b0, mi_e}) begin
            state_nxt = S_G_MIDIV;
          end else if (alu_res[DIVD_W-1:0] <= {{(DIVD_W-1){1'b0}}, 1'b1}) begin
            state_nxt = S_G_SMUL;
          end else begin
            state_nxt = S_G_WDDIV;
          end
        end
      end

      S_G_LMUL: begin
        if (iss_r && alu_done) begin
          // linear region ends at last max + max_increment * (b - 1)
          state_nxt = ({1'b0, w_r} < lm_plus_lin) ? S_G_BMUL : S_G_MIDIV;
        end
      end

      S_G_SMUL: begin
        if (iss_r && alu_done) begin
          tmp_nxt   = alu_res;
          state_nxt = S_G_SDIV;
        end
      end

      S_G_BMUL: begin
        if (iss_r && alu_done) begin
          tmp_nxt   = alu_res;
          state_nxt = S_G_BDIV;
        end
      end

      S_G_SDIV, S_G_BDIV, S_G_MIDIV, S_G_WDDIV: begin
        if (iss_r && alu_done) begin
          cnt_nxt   = fix_count(alu_res[DIVD_W-1:0], lm_r == '0);
          state_nxt = S_G_APPLY;
        end
      end

      S_G_APPLY: begin
        if ({8'b0, ack_r} > cnt_r) begin
          win_nxt = win_inc;
          ack_nxt = '0;
        end
        state_nxt = S_DONE;
      end

      // ---- loss ----
      S_C_WDIV: begin
        if (iss_r && alu_done) begin
          w_nxt     = qw;
          state_nxt = S_C_BMUL;
        end
      end

      S_C_BMUL: begin
        if (iss_r && alu_done) begin
          tmp_nxt = alu_res;
          if (FAST_CONVERGE && (w_r < lm_r)) begin
            lm_nxt = alu_res[WORD_W+BETA_SHIFT-1:BETA_SHIFT];
          end else begin
            lm_nxt = w_r;
          end
          state_nxt = (w_r < {16'b0, low_r}) ? S_C_QMUL : S_C_PMUL;
        end
      end

      S_C_QMUL, S_C_PMUL: begin
        if (iss_r && alu_done) begin
          th_nxt    = th_sat;
          win_nxt   = th_sat;
          state_nxt = S_DONE;
        end
      end

      // ---- result ----
      S_DONE: begin
        if (!ov_r || out_ready) begin
          ov_nxt    = 1'b1;
          ocw_nxt   = win_r;
          oth_nxt   = th_r;
          osw_nxt   = (rwnd_r < win_r) ? rwnd_r : win_r;
          oloss_nxt = loss_r;
          oretx_nxt = retx_r;
          opend_nxt = pend_r;
          state_nxt = S_IDLE;
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  assign out_valid                = ov_r;
  assign out_congestion_window    = ocw_r;
  assign out_slow_start_threshold = oth_r;
  assign out_send_window          = osw_r;
  assign out_in_loss              = oloss_r;
  assign out_retransmit_now       = oretx_r;
  assign out_send_pending         = opend_r;

endmodule
